FILE: rtl/cenc_pkg.sv
// Shared types, constants and AES-128 helper functions for the CENC sample encryptor.
package cenc_pkg;

   localparam int LENGTH_BITS_DEFAULT = 24;
   localparam int IV_BYTES_DEFAULT    = 8;
   localparam int QUEUE_DEPTH         = 4;
   localparam int KEY_BITS            = 128;
   localparam int CSR_DATA_BITS       = 64;
   localparam int CSR_INDEX_BITS      = 2;
   localparam logic [7:0] MIN_CLEAR_RESET = 8'd100;
   localparam logic [3:0] LAST_ROUND      = 4'd10;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_KEY_HIGH  = 2'd0,
      REG_KEY_LOW   = 2'd1,
      REG_MIN_CLEAR = 2'd2
   } csr_index_type;

   // one classified byte on its way from front to back
   typedef struct packed {
      logic [7:0]  data;
      logic        enc;
      logic [3:0]  pos_in_block;
      logic        new_block;
      logic        first;
      logic        last;
      logic [63:0] iv;
   } q_entry_type;

   localparam logic [2047:0] SBOX_TABLE = {
      128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
      128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
      128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
      128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
      128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
      128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
      128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
      128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16
   };

   function automatic logic [7:0] sbox(input logic [7:0] x);
      return SBOX_TABLE[(11'd2047 - {x, 3'b000}) -: 8];
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [7:0] rcon(input logic [3:0] round);
      logic [7:0] r;
      case (round)
         4'd1:    r = 8'h01;
         4'd2:    r = 8'h02;
         4'd3:    r = 8'h04;
         4'd4:    r = 8'h08;
         4'd5:    r = 8'h10;
         4'd6:    r = 8'h20;
         4'd7:    r = 8'h40;
         4'd8:    r = 8'h80;
         4'd9:    r = 8'h1b;
         4'd10:   r = 8'h36;
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   // next round key from the previous one
   function automatic logic [127:0] key_expand(input logic [127:0] rk, input logic [3:0] round);
      logic [31:0] w0, w1, w2, w3, t, n0, n1, n2, n3;
      w0 = rk[127:96];
      w1 = rk[95:64];
      w2 = rk[63:32];
      w3 = rk[31:0];
      t  = {sbox(w3[23:16]) ^ rcon(round), sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
      n0 = w0 ^ t;
      n1 = w1 ^ n0;
      n2 = w2 ^ n1;
      n3 = w3 ^ n2;
      return {n0, n1, n2, n3};
   endfunction

   // SubBytes, ShiftRows and (unless final) MixColumns; byte 0 is the top byte
   function automatic logic [127:0] aes_round(input logic [127:0] st, input logic final_round);
      logic [7:0]   tmp [16];
      logic [7:0]   sr  [16];
      logic [7:0]   a0, a1, a2, a3, s;
      logic [127:0] res;
      for (int i = 0; i < 16; i++) begin
         tmp[i] = sbox(st[127-8*i -: 8]);
      end
      for (int c = 0; c < 4; c++) begin
         for (int i = 0; i < 4; i++) begin
            sr[i+4*c] = tmp[i + 4*((c+i) & 3)];
         end
      end
      for (int c = 0; c < 4; c++) begin
         a0 = sr[4*c];
         a1 = sr[4*c+1];
         a2 = sr[4*c+2];
         a3 = sr[4*c+3];
         s  = a0 ^ a1 ^ a2 ^ a3;
         if (!final_round) begin
            sr[4*c]   = a0 ^ s ^ xtime(a0 ^ a1);
            sr[4*c+1] = a1 ^ s ^ xtime(a1 ^ a2);
            sr[4*c+2] = a2 ^ s ^ xtime(a2 ^ a3);
            sr[4*c+3] = a3 ^ s ^ xtime(a3 ^ a0);
         end
      end
      for (int i = 0; i < 16; i++) begin
         res[127-8*i -: 8] = sr[i];
      end
      return res;
   endfunction

endpackage

FILE: rtl/cenc_front.sv
// Front end: tracks byte position and clear lead, classifies each byte.
module cenc_front #(
   parameter int LENGTH_BITS = cenc_pkg::LENGTH_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic [7:0]                    data_byte,
   input  logic                          first_of_sample,
   input  logic                          last_of_sample,
   input  logic [LENGTH_BITS-1:0]        sample_length,
   input  logic [63:0]                   sample_iv,
   input  logic                          subsample_mode,
   input  logic [7:0]                    min_clear,
   output cenc_pkg::q_entry_type         entry,
   output logic [LENGTH_BITS-1:0]        clear_len
);

   logic [LENGTH_BITS-1:0] pos_ff, pos_in;
   logic [LENGTH_BITS-1:0] lead_ff, lead_in;
   logic [LENGTH_BITS-1:0] min_ext, over, pos, offset;

   always_comb begin
      min_ext = LENGTH_BITS'(min_clear);
      over    = sample_length - min_ext;
      lead_in = lead_ff;
      if (first_of_sample) begin
         if (!subsample_mode) begin
            lead_in = '0;
         end else if (sample_length <= min_ext) begin
            lead_in = sample_length;
         end else begin
            // length minus whole blocks above the minimum
            lead_in = min_ext + {{(LENGTH_BITS-4){1'b0}}, over[3:0]};
         end
      end
      pos    = first_of_sample ? '0 : pos_ff;
      pos_in = pos + 1'b1;
      offset = pos - lead_in;

      entry.data         = data_byte;
      entry.enc          = (pos >= lead_in);
      entry.pos_in_block = offset[3:0];
      entry.new_block    = (pos >= lead_in) && (offset[3:0] == 4'd0);
      entry.first        = first_of_sample;
      entry.last         = last_of_sample;
      entry.iv           = sample_iv;
      clear_len          = last_of_sample ? lead_in : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         lead_ff <= '0;
      end else if (accept) begin
         pos_ff  <= pos_in;
         lead_ff <= lead_in;
      end
   end

endmodule

FILE: rtl/cenc_fifo.sv
// Short queue between front and back.
module cenc_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = cenc_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             head_valid,
   output logic [WIDTH-1:0] head_data
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]    mem_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_BITS-1:0] count_ff;

   assign full       = (count_ff == CNT_BITS'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_BITS'(DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_BITS'(DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

FILE: rtl/cenc_back.sv
// Back end: keystream prefetch with an iterative AES core, XOR and output register.
module cenc_back #(
   parameter int LENGTH_BITS = cenc_pkg::LENGTH_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [127:0]           key,
   input  logic                   key_write,
   input  logic                   head_valid,
   input  cenc_pkg::q_entry_type  head,
   input  logic [LENGTH_BITS-1:0] head_clear_len,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [7:0]             rsp_out_byte,
   output logic                   rsp_was_encrypted,
   output logic                   rsp_end_of_sample,
   output logic [LENGTH_BITS-1:0] rsp_clear_length
);

   logic                   applied_ff;
   logic [63:0]            iv_ff, ctr_ff;
   logic [127:0]           ks_cur_ff, ks_next_ff;
   logic                   next_valid_ff, busy_ff;
   logic [3:0]             round_ff;
   logic [127:0]           st_ff, rk_ff, rk_n, st_n;
   logic                   rsp_valid_ff;
   logic [7:0]             out_byte_ff;
   logic                   was_enc_ff, eos_ff;
   logic [LENGTH_BITS-1:0] clear_len_ff;

   logic         apply, out_space, consume, start;
   logic [127:0] ks_sel;
   logic [7:0]   ks_byte;

   always_comb begin
      apply     = head_valid && head.first && !applied_ff;
      out_space = !rsp_valid_ff || rsp_ready;
      pop       = head_valid && out_space && (!head.new_block || (next_valid_ff && !apply));
      consume   = pop && head.new_block;
      start     = !busy_ff && !next_valid_ff && !apply && !key_write;
      ks_sel    = head.new_block ? ks_next_ff : ks_cur_ff;
      ks_byte   = ks_sel[(7'd127 - {head.pos_in_block, 3'b000}) -: 8];
      rk_n      = cenc_pkg::key_expand(rk_ff, round_ff);
      st_n      = cenc_pkg::aes_round(st_ff, round_ff == cenc_pkg::LAST_ROUND) ^ rk_n;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         applied_ff    <= 1'b0;
         iv_ff         <= '0;
         ctr_ff        <= '0;
         ks_cur_ff     <= '0;
         next_valid_ff <= 1'b0;
         busy_ff       <= 1'b0;
         round_ff      <= '0;
      end else begin
         if (pop) begin
            applied_ff <= 1'b0;
         end else if (apply) begin
            applied_ff <= 1'b1;
         end

         if (apply) begin
            iv_ff  <= head.iv;
            ctr_ff <= '0;
         end else if (consume) begin
            ctr_ff <= ctr_ff + 1'b1;
         end

         // new IV or new key: drop any prefetched block
         if (apply || key_write) begin
            busy_ff       <= 1'b0;
            next_valid_ff <= 1'b0;
         end else if (consume) begin
            ks_cur_ff     <= ks_next_ff;
            next_valid_ff <= 1'b0;
         end else if (start) begin
            busy_ff  <= 1'b1;
            round_ff <= 4'd1;
         end else if (busy_ff) begin
            if (round_ff == cenc_pkg::LAST_ROUND) begin
               next_valid_ff <= 1'b1;
               busy_ff       <= 1'b0;
            end else begin
               round_ff <= round_ff + 1'b1;
            end
         end
      end
   end

   // datapath of the AES core
   always_ff @(posedge clock) begin
      if (start) begin
         st_ff <= {iv_ff, ctr_ff} ^ key;
         rk_ff <= key;
      end else if (busy_ff) begin
         st_ff <= st_n;
         rk_ff <= rk_n;
         if (round_ff == cenc_pkg::LAST_ROUND) begin
            ks_next_ff <= st_n;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pop) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         out_byte_ff  <= head.data ^ (head.enc ? ks_byte : 8'h00);
         was_enc_ff   <= head.enc;
         eos_ff       <= head.last;
         clear_len_ff <= head_clear_len;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_byte      = out_byte_ff;
   assign rsp_was_encrypted = was_enc_ff;
   assign rsp_end_of_sample = eos_ff;
   assign rsp_clear_length  = clear_len_ff;

endmodule

FILE: rtl/cenc_aes128_ctr_sample_encryptor.sv
// Top level of the AES-128 CTR common-encryption sample encryptor.
//
// Bytes of a media sample enter on the req_ channel, one beat per byte; the
// first beat of a sample carries its IV, length and subsample mode. Each beat
// yields exactly one rsp_ beat, in order, with the ciphertext or clear byte.
// Keys and the minimum clear lead are written on the csr_ port while idle.
// With the keystream block ready, a req_ beat goes through the queue and the
// output register to its rsp_ beat. After a new IV (first byte) or a key
// write, the first encrypted byte waits while the iterative AES core (one
// round per cycle) makes the first block. Then the core prefetches the next
// counter block during the 16 bytes of the current one, so one byte per cycle
// is sustained while rsp_ready is high; a clear first byte waits for no block.
// A four-beat queue parts the input side from the AES/XOR side, and a single
// output register holds a result while the receiver stalls; the input keeps
// being taken until the queue fills.
// Reset clears keys to zero, the minimum clear lead to 100, IV and block
// counter to zero and empties the queue and output register.
module cenc_aes128_ctr_sample_encryptor #(
   parameter int LENGTH_BITS = cenc_pkg::LENGTH_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [7:0]                            req_data_byte,
   input  logic                                  req_first_of_sample,
   input  logic                                  req_last_of_sample,
   input  logic [LENGTH_BITS-1:0]                req_sample_length,
   input  logic [63:0]                           req_sample_iv,
   input  logic                                  req_subsample_mode,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [7:0]                            rsp_out_byte,
   output logic                                  rsp_was_encrypted,
   output logic                                  rsp_end_of_sample,
   output logic [LENGTH_BITS-1:0]                rsp_clear_length,
   input  logic                                  csr_write_enable,
   input  logic [cenc_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [cenc_pkg::CSR_DATA_BITS-1:0]    csr_write_data
);

   localparam int Q_WIDTH = $bits(cenc_pkg::q_entry_type) + LENGTH_BITS;

   // configuration registers
   logic [63:0] key_high_ff, key_low_ff;
   logic [7:0]  min_clear_ff;
   logic        key_write;

   cenc_pkg::q_entry_type  front_entry, head_entry;
   logic [LENGTH_BITS-1:0] front_clear_len, head_clear_len;
   logic                   accept, q_full, head_valid, pop;

   assign key_write = csr_write_enable &&
                      ((csr_index == cenc_pkg::REG_KEY_HIGH) ||
                       (csr_index == cenc_pkg::REG_KEY_LOW));

   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff  <= '0;
         key_low_ff   <= '0;
         min_clear_ff <= cenc_pkg::MIN_CLEAR_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            cenc_pkg::REG_KEY_HIGH:  key_high_ff  <= csr_write_data;
            cenc_pkg::REG_KEY_LOW:   key_low_ff   <= csr_write_data;
            cenc_pkg::REG_MIN_CLEAR: min_clear_ff <= csr_write_data[7:0];
            default: ;  // unused index, write dropped
         endcase
      end
   end

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   cenc_front #(.LENGTH_BITS(LENGTH_BITS)) u_front (
      .clock           (clock),
      .reset           (reset),
      .accept          (accept),
      .data_byte       (req_data_byte),
      .first_of_sample (req_first_of_sample),
      .last_of_sample  (req_last_of_sample),
      .sample_length   (req_sample_length),
      .sample_iv       (req_sample_iv),
      .subsample_mode  (req_subsample_mode),
      .min_clear       (min_clear_ff),
      .entry           (front_entry),
      .clear_len       (front_clear_len)
   );

   cenc_fifo #(.WIDTH(Q_WIDTH), .DEPTH(cenc_pkg::QUEUE_DEPTH)) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (accept),
      .push_data  ({front_entry, front_clear_len}),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_data  ({head_entry, head_clear_len})
   );

   cenc_back #(.LENGTH_BITS(LENGTH_BITS)) u_back (
      .clock             (clock),
      .reset             (reset),
      .key               ({key_high_ff, key_low_ff}),
      .key_write         (key_write),
      .head_valid        (head_valid),
      .head              (head_entry),
      .head_clear_len    (head_clear_len),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_was_encrypted (rsp_was_encrypted),
      .rsp_end_of_sample (rsp_end_of_sample),
      .rsp_clear_length  (rsp_clear_length)
   );

endmodule

FILE: rtl/cenc_checker.sv
// Port-level checker for the sample encryptor, bound to the top level.
module cenc_checker #(
   parameter int LENGTH_BITS = cenc_pkg::LENGTH_BITS_DEFAULT
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [7:0]             rsp_out_byte,
   input logic                   rsp_end_of_sample,
   input logic [LENGTH_BITS-1:0] rsp_clear_length
);

   // a held result keeps its byte
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte))
      else $error("rsp beat changed while stalled");

   // nothing comes out the cycle after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid after reset");

   // clear length is only reported on the last byte
   a_clear_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_end_of_sample |-> rsp_clear_length == '0)
      else $error("clear length on a non-final byte");

endmodule

bind cenc_aes128_ctr_sample_encryptor cenc_checker #(.LENGTH_BITS(LENGTH_BITS)) u_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_out_byte      (rsp_out_byte),
   .rsp_end_of_sample (rsp_end_of_sample),
   .rsp_clear_length  (rsp_clear_length)
);

FILE: test/cenc_aes128_ctr_sample_encryptor_tb.sv
// Self-checking testbench for the AES-128 CTR sample encryptor.
`timescale 1ns / 100ps

// Tracks keys, the minimum clear lead and the per-sample CTR state. It also keeps the
// ciphertext beats that are still owed by the block.
class cenc_ciphertext_board;
   typedef struct {
      logic [7:0]  out_byte;
      logic        was_encrypted;
      logic        end_of_sample;
      logic [23:0] clear_length;
   } cipher_beat_type;

   cipher_beat_type owed_beats[$];
   logic [63:0]  key_hi, key_lo;
   logic [7:0]   min_clear;
   logic [63:0]  iv_reg, blk_ctr;
   logic [127:0] keystream;
   logic [23:0]  byte_pos, clear_lead;
   logic         subsample;
   int           mismatches, beats_checked, encrypted_seen;

   function new();
      key_hi = '0; key_lo = '0; min_clear = cenc_pkg::MIN_CLEAR_RESET;
      iv_reg = '0; blk_ctr = '0; keystream = '0;
      byte_pos = '0; clear_lead = '0; subsample = 1'b0;
      mismatches = 0; beats_checked = 0; encrypted_seen = 0;
   endfunction

   function void write_reg(logic [1:0] idx, logic [63:0] data);
      case (idx)
         cenc_pkg::REG_KEY_HIGH:  key_hi = data;
         cenc_pkg::REG_KEY_LOW:   key_lo = data;
         cenc_pkg::REG_MIN_CLEAR: min_clear = data[7:0];
         default: ;  // unmapped index, dropped
      endcase
   endfunction

   function logic [7:0] sub_byte(logic [7:0] x);
      return cenc_pkg::SBOX_TABLE[2047 - 8*x -: 8];
   endfunction

   function logic [7:0] gf_double(logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function logic [127:0] aes_encrypt(logic [127:0] key, logic [127:0] pt);
      logic [31:0]  w [44];
      logic [31:0]  t;
      logic [7:0]   rc, a0, a1, a2, a3, s;
      logic [7:0]   st [16];
      logic [7:0]   sb [16];
      logic [127:0] ct;
      rc = 8'h01;
      for (int i = 0; i < 4; i++) w[i] = key[127-32*i -: 32];
      for (int i = 4; i < 44; i++) begin
         t = w[i-1];
         if ((i & 3) == 0) begin
            t = {sub_byte(t[23:16]) ^ rc, sub_byte(t[15:8]), sub_byte(t[7:0]),
                 sub_byte(t[31:24])};
            rc = gf_double(rc);
         end
         w[i] = w[i-4] ^ t;
      end
      for (int i = 0; i < 16; i++) st[i] = pt[127-8*i -: 8] ^ w[i/4][31-8*(i%4) -: 8];
      for (int r = 1; r <= 10; r++) begin
         for (int i = 0; i < 16; i++) sb[i] = sub_byte(st[i]);
         for (int c = 0; c < 4; c++)
            for (int i = 0; i < 4; i++) st[i+4*c] = sb[i + 4*((c+i) & 3)];
         if (r != 10) begin
            for (int c = 0; c < 4; c++) begin
               a0 = st[4*c]; a1 = st[4*c+1]; a2 = st[4*c+2]; a3 = st[4*c+3];
               s = a0 ^ a1 ^ a2 ^ a3;
               st[4*c]   = a0 ^ s ^ gf_double(a0 ^ a1);
               st[4*c+1] = a1 ^ s ^ gf_double(a1 ^ a2);
               st[4*c+2] = a2 ^ s ^ gf_double(a2 ^ a3);
               st[4*c+3] = a3 ^ s ^ gf_double(a3 ^ a0);
            end
         end
         for (int i = 0; i < 16; i++) st[i] ^= w[4*r + i/4][31-8*(i%4) -: 8];
      end
      for (int i = 0; i < 16; i++) ct[127-8*i -: 8] = st[i];
      return ct;
   endfunction

   // one accepted plaintext beat -> one owed ciphertext beat
   function void note_plain_beat(logic [7:0] data, logic first, logic last,
                                 logic [23:0] len, logic [63:0] iv, logic mode);
      cipher_beat_type exp_beat;
      logic [3:0]      k;
      exp_beat.out_byte = data;
      exp_beat.was_encrypted = 1'b0;
      if (first) begin
         iv_reg = iv;
         subsample = mode;
         if (!mode) clear_lead = '0;
         else if (len <= {16'd0, min_clear}) clear_lead = len;
         else clear_lead = len - (((len - {16'd0, min_clear}) >> 4) << 4);
         byte_pos = '0;
         blk_ctr = '0;
      end
      if (byte_pos >= clear_lead) begin
         k = byte_pos[3:0] - clear_lead[3:0];
         if (k == 4'd0) begin
            keystream = aes_encrypt({key_hi, key_lo}, {iv_reg, blk_ctr});
            blk_ctr++;
         end
         exp_beat.out_byte = data ^ keystream[127-8*k -: 8];
         exp_beat.was_encrypted = 1'b1;
      end
      byte_pos++;
      exp_beat.end_of_sample = last;
      exp_beat.clear_length = last ? clear_lead : '0;
      owed_beats.push_back(exp_beat);
   endfunction

   function void check_cipher_beat(logic [7:0] ob, logic enc, logic eos, logic [23:0] clr);
      cipher_beat_type e;
      beats_checked++;
      if (owed_beats.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected beat: byte %h enc %b", ob, enc);
         return;
      end
      e = owed_beats.pop_front();
      if (enc) encrypted_seen++;
      if (ob !== e.out_byte || enc !== e.was_encrypted || eos !== e.end_of_sample ||
          clr !== e.clear_length) begin
         mismatches++;
         if (mismatches <= 10)
            $display("beat %0d mismatch: exp byte %h enc %b eos %b clr %0d, got %h %b %b %0d",
                     beats_checked, e.out_byte, e.was_encrypted, e.end_of_sample,
                     e.clear_length, ob, enc, eos, clr);
      end
   endfunction

   function int owed();
      return owed_beats.size();
   endfunction
endclass

module cenc_aes128_ctr_sample_encryptor_tb;

   localparam int          CYCLE_LIMIT = 400000;
   localparam int          PLAIN_BEATS = 850;
   localparam logic [1:0]  REG_UNMAPPED = 2'd3;   // no register lives here

   logic        clock, reset;
   logic        req_valid, req_ready;
   logic [7:0]  req_data_byte;
   logic        req_first_of_sample, req_last_of_sample, req_subsample_mode;
   logic [23:0] req_sample_length;
   logic [63:0] req_sample_iv;
   logic        rsp_valid, rsp_ready;
   logic [7:0]  rsp_out_byte;
   logic        rsp_was_encrypted, rsp_end_of_sample;
   logic [23:0] rsp_clear_length;
   logic        csr_write_enable;
   logic [cenc_pkg::CSR_INDEX_BITS-1:0] csr_index;
   logic [cenc_pkg::CSR_DATA_BITS-1:0]  csr_write_data;

   cenc_ciphertext_board board;
   int send_idle_pct, recv_idle_pct;
   int cycles, beats_sent, samples_sent;

   cenc_aes128_ctr_sample_encryptor dut (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // cycle budget; a hang anywhere ends up here
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("cenc_aes128_ctr_sample_encryptor_tb: errors");
         $finish;
      end
   end

   // receiver back-pressure, redrawn every cycle
   always @(posedge clock) begin
      rsp_ready <= reset ? 1'b0 : ($urandom_range(99) >= recv_idle_pct);
   end

   // output monitor: values read here are the pre-edge ones
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         board.check_cipher_beat(rsp_out_byte, rsp_was_encrypted, rsp_end_of_sample,
                                 rsp_clear_length);
   end

   // three back-to-back register writes; enable drops once at the end
   task automatic load_config(input logic [63:0] kh, input logic [63:0] kl,
                              input logic [7:0] min_clr);
      logic [63:0] vals [3];
      vals[0] = kh; vals[1] = kl; vals[2] = {56'd0, min_clr};
      for (int i = 0; i < 3; i++) begin
         csr_write_enable <= 1'b1;
         csr_index <= cenc_pkg::csr_index_type'(i);
         csr_write_data <= vals[i];
         board.write_reg(i[1:0], vals[i]);
         @(posedge clock);
      end
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   // one beat; valid holds until the edge where ready is seen high
   task automatic send_beat(input logic [7:0] data, input logic first, input logic last,
                            input logic [23:0] len, input logic [63:0] iv,
                            input logic mode);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= data;
      req_first_of_sample <= first;
      req_last_of_sample <= last;
      req_sample_length <= len;
      req_sample_iv <= iv;
      req_subsample_mode <= mode;
      do @(posedge clock); while (!req_ready);
      board.note_plain_beat(data, first, last, len, iv, mode);
      beats_sent++;
   endtask

   // bytes of one sample; last_at < 0 means no last marker at all,
   // twice_last adds a second marker on the final beat
   task automatic send_sample(input int nbytes, input logic [23:0] stated, input logic mode,
                              input logic with_first, input int last_at,
                              input logic twice_last, input logic [63:0] iv);
      logic lst;
      samples_sent++;
      for (int i = 0; i < nbytes; i++) begin
         lst = (i == last_at) || (twice_last && i == nbytes - 1);
         send_beat(8'($urandom_range(255)), with_first && i == 0, lst,
                   (i == 0) ? stated : 24'($urandom), (i == 0) ? iv : {$urandom, $urandom},
                   (i == 0) ? mode : 1'($urandom));
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (board.owed() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic random_sample();
      int          n, pick;
      logic [23:0] stated;
      logic        mode;
      pick = $urandom_range(99);
      mode = 1'($urandom);
      if (pick < 70) n = $urandom_range(1, 48);
      else if (pick < 95) n = $urandom_range(49, 140);
      else n = $urandom_range(141, 300);
      stated = 24'(n);
      pick = $urandom_range(99);
      if (pick < 82) begin
         send_sample(n, stated, mode, 1'b1, n - 1, 1'b0, {$urandom, $urandom});
      end else if (pick < 87) begin
         // stated length disagrees with the real byte count
         stated = ($urandom_range(1)) ? 24'($urandom) : 24'(n + $urandom_range(1, 20));
         send_sample(n, stated, mode, 1'b1, n - 1, 1'b0, {$urandom, $urandom});
      end else if (pick < 92) begin
         // early last marker, then a repeated one at the true end
         send_sample(n, stated, mode, 1'b1, $urandom_range(0, n - 1), 1'b1,
                     {$urandom, $urandom});
      end else if (pick < 96) begin
         // no first marker: bytes carry on the previous sample's state
         send_sample(n, stated, mode, 1'b0, n - 1, 1'b0, {$urandom, $urandom});
      end else begin
         send_sample(n, stated, mode, 1'b1, -1, 1'b0, {$urandom, $urandom});
      end
   endtask

   initial begin
      board = new();
      cycles = 0; beats_sent = 0; samples_sent = 0;
      send_idle_pct = 15; recv_idle_pct = 79;
      reset = 1'b1;
      req_valid = 1'b0; req_data_byte = '0; req_first_of_sample = 1'b0;
      req_last_of_sample = 1'b0; req_sample_length = '0; req_sample_iv = '0;
      req_subsample_mode = 1'b0;
      csr_write_enable = 1'b0; csr_index = cenc_pkg::REG_KEY_HIGH; csr_write_data = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: bytes ahead of any sample start use reset state (zero key, zero IV)
      send_beat(8'h00, 1'b0, 1'b0, 24'hffffff, '1, 1'b1);
      send_beat(8'hff, 1'b0, 1'b1, 24'h000000, '0, 1'b0);
      drain();
      load_config({$urandom, $urandom}, {$urandom, $urandom}, 8'd4);
      // full mode, short partial block
      send_sample(3, 24'd3, 1'b0, 1'b1, 2, 1'b0, 64'hffff_ffff_ffff_ffff);
      // subsample at exactly the clear threshold: stays clear
      send_sample(4, 24'd4, 1'b1, 1'b1, 3, 1'b0, 64'h0);
      // stated length shorter than the real sample; the lead does not grow
      send_sample(4, 24'd2, 1'b1, 1'b1, 3, 1'b0, {$urandom, $urandom});
      // early last, repeated last
      send_sample(4, 24'd4, 1'b0, 1'b1, 1, 1'b1, {$urandom, $urandom});
      // key change in the middle of a keystream block
      send_sample(5, 24'd10, 1'b0, 1'b1, -1, 1'b0, {$urandom, $urandom});
      drain();
      load_config({$urandom, $urandom}, '0, 8'd4);
      send_sample(5, 24'd0, 1'b0, 1'b0, 4, 1'b0, '0);
      drain();

      // random: six phases, each with its own settings; idling follows phase/2
      for (int ph = 0; ph < 6; ph++) begin
         case (ph / 2)
            0:       begin send_idle_pct = 15; recv_idle_pct = 79; end
            1:       begin send_idle_pct = 79; recv_idle_pct = 15; end
            default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
         endcase
         case (ph)
            0: load_config({$urandom, $urandom}, {$urandom, $urandom}, 8'd0);
            1: load_config('1, '1, 8'd255);
            2: begin
               // unmapped index must leave every register alone
               csr_write_enable <= 1'b1;
               csr_index <= REG_UNMAPPED;
               csr_write_data <= {$urandom, $urandom};
               @(posedge clock);
               load_config({$urandom, $urandom}, {$urandom, $urandom}, 8'($urandom));
            end
            3: load_config('0, '0, 8'd16);
            4: load_config({$urandom, $urandom}, {$urandom, $urandom}, 8'd1);
            default: load_config({$urandom, $urandom}, {$urandom, $urandom}, 8'd100);
         endcase
         while (beats_sent < (ph + 1) * PLAIN_BEATS / 6 + 25) random_sample();
         drain();
      end

      $display("%0d beats in %0d samples, %0d encrypted; keys and clear minimum swept 0..255",
               beats_sent, samples_sent, board.encrypted_seen);
      if (board.mismatches == 0 && board.owed() == 0) begin
         $display("cenc_aes128_ctr_sample_encryptor_tb: clean");
      end else begin
         $display("%0d mismatches, %0d beats never returned", board.mismatches, board.owed());
         $display("cenc_aes128_ctr_sample_encryptor_tb: errors");
      end
      $finish;
   end
endmodule
